FILE: hdl/sdcg_pkg.sv
// Package for the segment display command generator.
// Holds the shared constants, action codes and the BCD conversion step.
// Has no dependencies.
`default_nettype none

package sdcg_pkg;

  // display geometry
  localparam int DIGITS     = 8;
  localparam int NUM_CHIPS  = 4;

  // field widths
  localparam int ACTION_W   = 3;
  localparam int SEL_W      = 3;
  localparam int VALUE_W    = 32;
  localparam int POS_W      = 8;
  localparam int BYTE_W     = 8;
  localparam int MASK_W     = 4;
  localparam int REG_W      = 4;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int CNT_W      = $clog2(VALUE_W);

  // action codes
  localparam logic [ACTION_W-1:0] ACT_NUMBER    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_TIME      = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_LETTER    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR_ONE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR_ALL = 3'd4;

  // driver register addresses and data codes
  localparam logic [REG_W-1:0]  REG_DECODE  = 4'h9;
  localparam logic [BYTE_W-1:0] CH_BLANK    = 8'h0F;
  localparam logic [BYTE_W-1:0] CH_MINUS    = 8'h0A;
  localparam logic [BYTE_W-1:0] DECODE_ALL  = 8'hFF;
  localparam logic [BYTE_W-1:0] DECODE_NONE = 8'h00;
  localparam logic [REG_W-1:0]  DP_DIGIT    = 4'd4;
  localparam logic [MASK_W-1:0] MASK_ALL    = MASK_W'((1 << NUM_CHIPS) - 1);

  // command kinds kept while frames go out
  typedef enum logic [1:0] {
    KIND_NUM,
    KIND_LET,
    KIND_CLR
  } kind_t;

  // one double-dabble step: adjust each digit, then shift in the next binary bit
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                               input logic bin_bit);
    logic [BCD_W-1:0] adj;
    logic [3:0]       nib;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      nib = bcd[4*i +: 4];
      if (nib >= 4'd5) begin
        nib = nib + 4'd3;
      end
      adj[4*i +: 4] = nib;
    end
    return {adj[BCD_W-2:0], bin_bit};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/segment_display_command_generator_top.sv
// Sequence: number and time commands run the binary to BCD conversion, one prep step and then
// send their frames through the output register; other commands go straight to their frames.
// Throughput: one command at a time, in_stall is high while the sequencer is busy; one frame
// per cycle while not stalled.
// Reset (synchronous, active low) clears the sequencer, the output valid and decode flags.
// Depends on sdcg_pkg.
`default_nettype none

module segment_display_command_generator_top (
  input  wire                         clk,
  input  wire                         rst_n,
  // command channel
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  [sdcg_pkg::ACTION_W-1:0] in_action,
  input  wire  [sdcg_pkg::SEL_W-1:0]    in_display_select,
  input  wire  signed [sdcg_pkg::VALUE_W-1:0] in_value,
  input  wire  signed [sdcg_pkg::POS_W-1:0]   in_digit_pos,
  input  wire  [sdcg_pkg::BYTE_W-1:0]   in_letter_code,
  // frame channel
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [sdcg_pkg::MASK_W-1:0] out_chip_mask,
  output logic [sdcg_pkg::REG_W-1:0]  out_reg_addr,
  output logic [sdcg_pkg::BYTE_W-1:0] out_reg_data,
  output logic                        out_last
);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CONV  = 4'd1;
  localparam logic [3:0] S_PREP  = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_BLANK = 4'd4;
  localparam logic [3:0] S_ZERO  = 4'd5;
  localparam logic [3:0] S_DIG   = 4'd6;
  localparam logic [3:0] S_MINUS = 4'd7;
  localparam logic [3:0] S_LET   = 4'd8;

  localparam logic [sdcg_pkg::REG_W-1:0] DIGITS_R = sdcg_pkg::REG_W'(sdcg_pkg::DIGITS);
  localparam logic [sdcg_pkg::CNT_W-1:0] CONV_LAST = sdcg_pkg::CNT_W'(sdcg_pkg::VALUE_W - 1);

  // control registers
  logic [3:0]                  state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [sdcg_pkg::MASK_W-1:0] decode_on_r, decode_on_nxt;

  // command context registers
  logic [sdcg_pkg::MASK_W-1:0]  mask_r, mask_nxt;
  sdcg_pkg::kind_t              kind_r, kind_nxt;
  logic                         timed_r, timed_nxt;
  logic                         neg_r, neg_nxt;
  logic                         need_dec_r, need_dec_nxt;
  logic                         zero_r, zero_nxt;
  logic [sdcg_pkg::BYTE_W-1:0]  dec_data_r, dec_data_nxt;
  logic [sdcg_pkg::BYTE_W-1:0]  blank_data_r, blank_data_nxt;
  logic [sdcg_pkg::REG_W-1:0]   let_reg_r, let_reg_nxt;
  logic [sdcg_pkg::BYTE_W-1:0]  let_data_r, let_data_nxt;
  logic [sdcg_pkg::REG_W-1:0]   blank_r, blank_nxt;
  logic [sdcg_pkg::REG_W-1:0]   pos_r, pos_nxt;
  logic [sdcg_pkg::REG_W-1:0]   ndig_r, ndig_nxt;
  logic [sdcg_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [sdcg_pkg::VALUE_W-1:0] bin_r, bin_nxt;
  logic [sdcg_pkg::BCD_W-1:0]   bcd_r, bcd_nxt;

  // output frame registers
  logic [sdcg_pkg::MASK_W-1:0] o_mask_r, o_mask_nxt;
  logic [sdcg_pkg::REG_W-1:0]  o_reg_r, o_reg_nxt;
  logic [sdcg_pkg::BYTE_W-1:0] o_data_r, o_data_nxt;
  logic                        o_last_r, o_last_nxt;

  // frame built by the current state
  logic                        emit;
  logic                        fire;
  logic [sdcg_pkg::REG_W-1:0]  f_reg;
  logic [sdcg_pkg::BYTE_W-1:0] f_data;
  logic                        f_last;
  logic                        dig_end;
  logic                        minus_need;

  // accept-side decode
  logic                         sel_ok;
  logic [sdcg_pkg::MASK_W-1:0]  sel_mask;
  logic [sdcg_pkg::VALUE_W-1:0] in_mag;
  logic [sdcg_pkg::REG_W-1:0]   in_let_reg;
  logic [sdcg_pkg::REG_W-1:0]   bcd_ndig;

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_chip_mask = o_mask_r;
  assign out_reg_addr  = o_reg_r;
  assign out_reg_data  = o_data_r;
  assign out_last      = o_last_r;

  // chip select and magnitude of the incoming command
  always_comb begin
    sel_ok   = (in_display_select >= sdcg_pkg::SEL_W'(1)) &&
               (in_display_select <= sdcg_pkg::SEL_W'(sdcg_pkg::NUM_CHIPS));
    sel_mask = sel_ok ? sdcg_pkg::MASK_W'(1 << (in_display_select - sdcg_pkg::SEL_W'(1)))
                      : '0;
    in_mag   = in_value[sdcg_pkg::VALUE_W-1] ? (~in_value + sdcg_pkg::VALUE_W'(1))
                                              : in_value;
  end

  // letter register: position clamped to 0..DIGITS, register is DIGITS - position
  always_comb begin
    if (in_digit_pos[sdcg_pkg::POS_W-1]) begin
      in_let_reg = DIGITS_R;
    end else if (in_digit_pos > sdcg_pkg::POS_W'(sdcg_pkg::DIGITS)) begin
      in_let_reg = '0;
    end else begin
      in_let_reg = DIGITS_R - in_digit_pos[sdcg_pkg::REG_W-1:0];
    end
  end

  // number of decimal digits held in the bcd register, at least one
  always_comb begin
    bcd_ndig = sdcg_pkg::REG_W'(1);
    for (int i = 0; i < sdcg_pkg::BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        bcd_ndig = sdcg_pkg::REG_W'(i + 1);
      end
    end
  end

  // frame contents per state
  always_comb begin
    minus_need = neg_r && (ndig_r < DIGITS_R);
    dig_end    = (pos_r == ndig_r) || (pos_r == DIGITS_R);
    emit       = 1'b0;
    f_reg      = '0;
    f_data     = '0;
    f_last     = 1'b0;
    unique case (state_r)
      S_DEC: begin
        emit   = 1'b1;
        f_reg  = sdcg_pkg::REG_DECODE;
        f_data = dec_data_r;
      end
      S_BLANK: begin
        emit   = 1'b1;
        f_reg  = blank_r;
        f_data = blank_data_r;
        f_last = (blank_r == sdcg_pkg::REG_W'(1)) && (kind_r != sdcg_pkg::KIND_NUM);
      end
      S_ZERO: begin
        emit   = 1'b1;
        f_reg  = sdcg_pkg::REG_W'(1);
      end
      S_DIG: begin
        emit   = 1'b1;
        f_reg  = pos_r;
        f_data = {(timed_r && (pos_r == sdcg_pkg::DP_DIGIT)), 3'b000, bcd_r[3:0]};
        f_last = dig_end && !minus_need;
      end
      S_MINUS: begin
        emit   = 1'b1;
        f_reg  = ndig_r + sdcg_pkg::REG_W'(1);
        f_data = sdcg_pkg::CH_MINUS;
        f_last = 1'b1;
      end
      S_LET: begin
        emit   = 1'b1;
        f_reg  = let_reg_r;
        f_data = let_data_r;
        f_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    fire = emit && (!out_valid_r || !out_stall);
  end

  // output register: load on a new frame, drop after a transfer
  always_comb begin
    o_mask_nxt = o_mask_r;
    o_reg_nxt  = o_reg_r;
    o_data_nxt = o_data_r;
    o_last_nxt = o_last_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      o_mask_nxt    = mask_r;
      o_reg_nxt     = f_reg;
      o_data_nxt    = f_data;
      o_last_nxt    = f_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    decode_on_nxt  = decode_on_r;
    mask_nxt       = mask_r;
    kind_nxt       = kind_r;
    timed_nxt      = timed_r;
    neg_nxt        = neg_r;
    need_dec_nxt   = need_dec_r;
    zero_nxt       = zero_r;
    dec_data_nxt   = dec_data_r;
    blank_data_nxt = blank_data_r;
    let_reg_nxt    = let_reg_r;
    let_data_nxt   = let_data_r;
    blank_nxt      = blank_r;
    pos_nxt        = pos_r;
    ndig_nxt       = ndig_r;
    cnt_nxt        = cnt_r;
    bin_nxt        = bin_r;
    bcd_nxt        = bcd_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mask_nxt = sel_mask;
          unique case (in_action)
            sdcg_pkg::ACT_NUMBER, sdcg_pkg::ACT_TIME: begin
              if (sel_ok) begin
                kind_nxt       = sdcg_pkg::KIND_NUM;
                timed_nxt      = (in_action == sdcg_pkg::ACT_TIME);
                neg_nxt        = in_value[sdcg_pkg::VALUE_W-1];
                need_dec_nxt   = ((decode_on_r & sel_mask) == '0);
                dec_data_nxt   = sdcg_pkg::DECODE_ALL;
                blank_data_nxt = sdcg_pkg::CH_BLANK;
                decode_on_nxt  = decode_on_r | sel_mask;
                bin_nxt        = in_mag;
                bcd_nxt        = '0;
                cnt_nxt        = '0;
                state_nxt      = S_CONV;
              end
            end
            sdcg_pkg::ACT_LETTER: begin
              if (sel_ok) begin
                kind_nxt      = sdcg_pkg::KIND_LET;
                dec_data_nxt  = sdcg_pkg::DECODE_NONE;
                let_reg_nxt   = in_let_reg;
                let_data_nxt  = in_letter_code;
                decode_on_nxt = decode_on_r & ~sel_mask;
                state_nxt     = S_DEC;
              end
            end
            sdcg_pkg::ACT_CLEAR_ONE: begin
              if (sel_ok) begin
                kind_nxt       = sdcg_pkg::KIND_CLR;
                blank_data_nxt = ((decode_on_r & sel_mask) != '0) ? sdcg_pkg::CH_BLANK
                                                                   : sdcg_pkg::DECODE_NONE;
                blank_nxt      = DIGITS_R;
                state_nxt      = S_BLANK;
              end
            end
            sdcg_pkg::ACT_CLEAR_ALL: begin
              kind_nxt       = sdcg_pkg::KIND_CLR;
              mask_nxt       = sdcg_pkg::MASK_ALL;
              dec_data_nxt   = sdcg_pkg::DECODE_NONE;
              blank_data_nxt = sdcg_pkg::DECODE_NONE;
              decode_on_nxt  = '0;
              state_nxt      = S_DEC;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      // binary to bcd, one bit per cycle
      S_CONV: begin
        bcd_nxt = sdcg_pkg::dd_step(bcd_r, bin_r[sdcg_pkg::VALUE_W-1]);
        bin_nxt = {bin_r[sdcg_pkg::VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + sdcg_pkg::CNT_W'(1);
        if (cnt_r == CONV_LAST) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        ndig_nxt  = bcd_ndig;
        zero_nxt  = (bcd_r == '0);
        blank_nxt = DIGITS_R;
        state_nxt = need_dec_r ? S_DEC : S_BLANK;
      end
      S_DEC: begin
        if (fire) begin
          blank_nxt = DIGITS_R;
          state_nxt = (kind_r == sdcg_pkg::KIND_LET) ? S_LET : S_BLANK;
        end
      end
      S_BLANK: begin
        if (fire) begin
          blank_nxt = blank_r - sdcg_pkg::REG_W'(1);
          pos_nxt   = sdcg_pkg::REG_W'(1);
          if (blank_r == sdcg_pkg::REG_W'(1)) begin
            if (kind_r == sdcg_pkg::KIND_NUM) begin
              state_nxt = zero_r ? S_ZERO : S_DIG;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_ZERO: begin
        if (fire) begin
          state_nxt = S_DIG;
        end
      end
      // digits go out least significant first
      S_DIG: begin
        if (fire) begin
          bcd_nxt = {4'd0, bcd_r[sdcg_pkg::BCD_W-1:4]};
          pos_nxt = pos_r + sdcg_pkg::REG_W'(1);
          if (dig_end) begin
            state_nxt = minus_need ? S_MINUS : S_IDLE;
          end
        end
      end
      S_MINUS, S_LET: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      decode_on_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      decode_on_r <= decode_on_nxt;
    end
  end

  // payload and context
  always_ff @(posedge clk) begin
    mask_r       <= mask_nxt;
    kind_r       <= kind_nxt;
    timed_r      <= timed_nxt;
    neg_r        <= neg_nxt;
    need_dec_r   <= need_dec_nxt;
    zero_r       <= zero_nxt;
    dec_data_r   <= dec_data_nxt;
    blank_data_r <= blank_data_nxt;
    let_reg_r    <= let_reg_nxt;
    let_data_r   <= let_data_nxt;
    blank_r      <= blank_nxt;
    pos_r        <= pos_nxt;
    ndig_r       <= ndig_nxt;
    cnt_r        <= cnt_nxt;
    bin_r        <= bin_nxt;
    bcd_r        <= bcd_nxt;
    o_mask_r     <= o_mask_nxt;
    o_reg_r      <= o_reg_nxt;
    o_data_r     <= o_data_nxt;
    o_last_r     <= o_last_nxt;
  end

endmodule

`default_nettype wire
